@@ rtl/io_register_file_joypad_div_macros.svh @@
// Assertion macros shared by the I/O register file RTL.
// No dependencies; included by the modules that carry assertions.
// The including module must provide clk and rst_n.
`ifndef IO_REGISTER_FILE_JOYPAD_DIV_MACROS_SVH
`define IO_REGISTER_FILE_JOYPAD_DIV_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define IORF_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define IORF_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define IORF_ASSERT_IMPL(name, pre, post)
`define IORF_ASSERT_NEXT(name, pre, post)
`endif

`endif

@@ rtl/iorf_pkg.sv @@
// Package for the I/O register file: item, result and internal struct types,
// register offsets, bit masks, command codes and the joypad byte function.
// No dependencies.
package iorf_pkg;

    // Default size of the register area in bytes.
    localparam int IO_BYTES_DEFAULT = 128;

    // Command codes.
    localparam logic [2:0] CMD_WRITE     = 3'd0;
    localparam logic [2:0] CMD_READ      = 3'd1;
    localparam logic [2:0] CMD_KEY       = 3'd2;
    localparam logic [2:0] CMD_DIV_RESET = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    // Register offsets with special behavior.
    localparam logic [6:0] OFS_JOYPAD  = 7'h00;
    localparam logic [6:0] OFS_DIVIDER = 7'h04;
    localparam logic [6:0] OFS_STATUS  = 7'h41;

    // Joypad and status bit masks.
    localparam logic [7:0] JOY_SEL_MASK   = 8'h30;
    localparam logic [7:0] JOY_FIXED      = 8'hCF;
    localparam logic [7:0] JOY_BTN_SEL    = 8'h20;
    localparam logic [7:0] JOY_DIR_SEL    = 8'h10;
    localparam logic [7:0] STATUS_WR_MASK = 8'h78;
    localparam logic [7:0] STATUS_FORCE   = 8'h80;
    localparam logic [3:0] KEYS_RELEASED  = 4'hF;

    // One input transaction.
    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] offset;
        logic [7:0] wdata;
        logic [2:0] key;
        logic       pressed;
    } iorf_item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] rdata;
        logic       keys_changed;
    } iorf_result_t;

    // Request from the control stage to the byte store.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [6:0] addr;
        logic [7:0] wdata;
    } iorf_mem_req_t;

    // Where the read data of a transaction comes from.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_MEM,
        SRC_DIRECT
    } iorf_src_t;

    // Control stage output handed to the result register.
    typedef struct packed {
        logic       vld;
        iorf_src_t  src;
        logic [7:0] direct;
        logic       changed;
    } iorf_stage_t;

    // Joypad byte: select bits, ones in bits 7..6, and the selected
    // active-low key nibbles merged into the low nibble.
    function automatic logic [7:0] joypad_value(input logic [7:0] sel,
                                                input logic [3:0] btn,
                                                input logic [3:0] dir);
        logic [7:0] v;
        v = sel | JOY_FIXED;
        if ((sel & JOY_BTN_SEL) == 8'h00)
            v = v & {4'hF, btn};
        if ((sel & JOY_DIR_SEL) == 8'h00)
            v = v & {4'hF, dir};
        return v;
    endfunction

endpackage

@@ rtl/iorf_store.sv @@
// Byte store of the I/O register file: one write and one registered read
// per cycle, with per-entry valid bits so unwritten entries read as zero.
// Depends on iorf_pkg.
module iorf_store #(
    parameter int IO_BYTES = iorf_pkg::IO_BYTES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iorf_pkg::iorf_mem_req_t req,
    output logic [7:0]             rdata
);
    import iorf_pkg::*;

    localparam int ADDR_W = $clog2(IO_BYTES);

    logic [7:0]          mem [IO_BYTES];
    logic [IO_BYTES-1:0] vld_reg;
    logic [7:0]          mem_q_reg;
    logic                hit_reg;
    logic [ADDR_W-1:0]   addr;

    // The control stage only enables a write for offsets inside the store.
    assign addr = ADDR_W'(req.addr);

    // Storage array and its registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[addr] <= req.wdata;
        if (req.rd_en)
            mem_q_reg <= mem[addr];
    end

    // Valid bits stand in for clearing the array at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                vld_reg[addr] <= 1'b1;
            if (req.rd_en)
                hit_reg <= vld_reg[addr];
        end
    end

    // An entry that was never written reads as its reset value of zero.
    assign rdata = hit_reg ? mem_q_reg : 8'h00;

endmodule

@@ rtl/iorf_ctrl.sv @@
// Command decode of the I/O register file: system counter, key state,
// joypad byte, store requests and the first pipeline register.
// Depends on iorf_pkg and io_register_file_joypad_div_macros.svh.
`include "io_register_file_joypad_div_macros.svh"

module iorf_ctrl #(
    parameter int IO_BYTES = iorf_pkg::IO_BYTES_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  iorf_pkg::iorf_item_t    item,
    output iorf_pkg::iorf_mem_req_t req,
    output iorf_pkg::iorf_stage_t   stage
);
    import iorf_pkg::*;

    localparam logic [8:0] STORE_LIMIT = 9'(IO_BYTES);

    logic [15:0] cnt_reg, cnt_next;
    logic [3:0]  btn_reg, btn_next;
    logic [3:0]  dir_reg, dir_next;
    logic [7:0]  joy_reg, joy_next;
    iorf_stage_t stage_reg, stage_next;
    logic        in_store;
    logic [3:0]  key_bit;
    logic [3:0]  nb;
    logic [3:0]  nd;
    logic        key_diff;

    assign in_store = ({2'b00, item.offset} < STORE_LIMIT);

    // New key state for a key event; the upper key codes are directions.
    always_comb
    begin
        key_bit = 4'b0001 << item.key[1:0];
        nb      = btn_reg;
        nd      = dir_reg;
        if (!item.key[2])
            nb = item.pressed ? (btn_reg & ~key_bit) : (btn_reg | key_bit);
        else
            nd = item.pressed ? (dir_reg & ~key_bit) : (dir_reg | key_bit);
        key_diff = (nb != btn_reg) || (nd != dir_reg);
    end

    // Command decode. The status byte is only ever written through the
    // masked path, so its own low bits stay at their reset value of zero.
    always_comb
    begin
        cnt_next           = cnt_reg;
        btn_next           = btn_reg;
        dir_next           = dir_reg;
        joy_next           = joy_reg;
        req.wr_en          = 1'b0;
        req.rd_en          = accept;
        req.addr           = item.offset;
        req.wdata          = item.wdata;
        stage_next.vld     = accept;
        stage_next.src     = SRC_NONE;
        stage_next.direct  = 8'h00;
        stage_next.changed = 1'b0;
        if (accept)
        begin
            case (item.cmd)
                CMD_WRITE:
                begin
                    if (item.offset == OFS_DIVIDER)
                        cnt_next = 16'h0000;
                    else if (!in_store)
                        cnt_next = cnt_reg;
                    else if (item.offset == OFS_JOYPAD)
                        joy_next = joypad_value(item.wdata & JOY_SEL_MASK, btn_reg, dir_reg);
                    else if (item.offset == OFS_STATUS)
                    begin
                        req.wr_en = 1'b1;
                        req.wdata = (item.wdata & STATUS_WR_MASK) | STATUS_FORCE;
                    end
                    else
                        req.wr_en = 1'b1;
                end
                CMD_READ:
                begin
                    if (item.offset == OFS_DIVIDER)
                    begin
                        stage_next.src    = SRC_DIRECT;
                        stage_next.direct = cnt_reg[15:8];
                    end
                    else if (in_store && (item.offset == OFS_JOYPAD))
                    begin
                        stage_next.src    = SRC_DIRECT;
                        stage_next.direct = joy_reg;
                    end
                    else if (in_store)
                        stage_next.src = SRC_MEM;
                end
                CMD_KEY:
                begin
                    if (key_diff)
                    begin
                        btn_next           = nb;
                        dir_next           = nd;
                        stage_next.changed = 1'b1;
                        joy_next           = joypad_value(joy_reg & JOY_SEL_MASK, nb, nd);
                    end
                end
                CMD_DIV_RESET:
                    cnt_next = 16'h0000;
                CMD_TICK:
                    cnt_next = cnt_reg + 16'd1;
                default:
                    cnt_next = cnt_reg;
            endcase
        end
    end

    // Architectural state and the first pipeline register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 16'h0000;
            btn_reg   <= KEYS_RELEASED;
            dir_reg   <= KEYS_RELEASED;
            joy_reg   <= 8'h00;
            stage_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            btn_reg   <= btn_next;
            dir_reg   <= dir_next;
            joy_reg   <= joy_next;
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

    // A divider reset command always leaves the counter at zero.
    `IORF_ASSERT_NEXT(a_div_reset_clears, accept && (item.cmd == CMD_DIV_RESET), cnt_reg == 16'h0000)
    // A tick advances the counter by exactly one.
    `IORF_ASSERT_NEXT(a_tick_counts, accept && (item.cmd == CMD_TICK), cnt_reg == 16'($past(cnt_reg) + 16'd1))
    // Once the joypad byte is computed, its two top bits read as one.
    `IORF_ASSERT_IMPL(a_joy_top_bits, joy_reg != 8'h00, joy_reg[7:6] == 2'b11)

endmodule

@@ rtl/io_register_file_joypad_div.sv @@
// Top level of the I/O register file with joypad matrix and system divider.
// Depends on iorf_pkg, iorf_ctrl, iorf_store and the assertion macro header.
//
// Usage:
//   A transaction is accepted at a rising clock edge where start is high and
//   busy is low. busy stays low, so one transaction can be taken every cycle.
//   item carries the command (write, read, key event, divider reset, tick),
//   the register offset, the write byte and the key event fields.
//   Every accepted transaction produces exactly one result: done is high for
//   one cycle once the transaction has passed the first pipeline register
//   and the result register, and result holds the read byte (zero for
//   anything but a read) and the key-changed flag. Throughput is 1
//   transaction per cycle: the command decode and the store's read port feed
//   the first pipeline register, the read data selection the result register.
//   A read observes all writes of earlier transactions, including the one
//   accepted in the cycle just before.
//   Reset clears the register area to zero, the system counter to zero and
//   the keys to released; no clearing pass is needed.
//   The receiver cannot stall; results must be taken when done is high.
`include "io_register_file_joypad_div_macros.svh"

module io_register_file_joypad_div #(
    parameter int IO_BYTES = iorf_pkg::IO_BYTES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  iorf_pkg::iorf_item_t   item,
    output logic                   done,
    output iorf_pkg::iorf_result_t result
);
    import iorf_pkg::*;

    logic          accept;
    iorf_mem_req_t req;
    iorf_stage_t   stage;
    logic [7:0]    store_rdata;
    logic          done_reg;
    iorf_result_t  result_reg, result_next;

    // The block never holds off a transaction.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    iorf_ctrl #(
        .IO_BYTES (IO_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .req    (req),
        .stage  (stage)
    );

    iorf_store #(
        .IO_BYTES (IO_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (store_rdata)
    );

    // Read data selection.
    always_comb
    begin
        result_next.keys_changed = stage.changed;
        case (stage.src)
            SRC_MEM:    result_next.rdata = store_rdata;
            SRC_DIRECT: result_next.rdata = stage.direct;
            default:    result_next.rdata = 8'h00;
        endcase
    end

    // Result register; only the strobe needs a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage.vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted transaction returns its result with a done strobe.
    `IORF_ASSERT_IMPL(a_result_follows, start && !busy, ##2 done)
    // No result appears without an accepted transaction.
    `IORF_ASSERT_IMPL(a_no_spurious, !(start && !busy), ##2 !done)
    // A key event result never carries read data.
    `IORF_ASSERT_IMPL(a_changed_no_data, done && result.keys_changed, result.rdata == 8'h00)

endmodule
